### rtl/core/drld_pkg.sv
// Shared types and constants for the run list decoder.
package drld_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned CLUS_W   = 63;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned OUT_TDATA_W = 256;
    localparam int unsigned APB_AW   = 4;

    localparam logic [NIB_W-1:0] MAX_NIBBLE = 4'd8;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2
    } t_phase;

    localparam logic [STAT_W-1:0] ST_RUN       = 3'd0;
    localparam logic [STAT_W-1:0] ST_END       = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_NIB   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NEG_LEN   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NEG_LCN   = 3'd4;
    localparam logic [STAT_W-1:0] ST_VCN_BOUND = 3'd5;

    // register index taken from the 8-byte register slot
    localparam logic REG_VCN_BOUND = 1'b0;

endpackage

### rtl/core/data_run_list_decoder.sv
// Run list (mapping pairs) decoder: one byte per cycle unless stalled; one result per run, end or failure.
//
//  channel    | dir | handshake                 | payload
//  -----------+-----+---------------------------+-----------------------------------------
//  s_axis     | in  | s_axis_tvalid/tready      | tdata: data_byte; tuser: list_start
//  m_axis     | out | m_axis_tvalid/tready      | tdata: lcn, clusters, first, end vcn;
//             |     |                           | tuser: status; tlast: list_done
//  apb        | in  | psel/penable/pwrite       | vcn_bound at byte address 0
//
// One byte is accepted per cycle unless the output stalls; a result appears in the cycle after
// the byte that completes a run or ends the list. The path from the byte to the result register
// holds one 64-bit add for the logical cluster and one three-input add plus a
// 64-bit compare for the virtual cluster bound. Reset is synchronous and clears all
// decoder state and vcn_bound. A stalled output holds s_axis_tready low only while
// the result register is full and not being taken.
module data_run_list_decoder
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [drld_pkg::DATA_W-1:0]         s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                          s_axis_tuser,  // [0] list_start

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [63:0] run_lcn, [126:64] run_clusters, [190:127] run_first_vcn,
    // [254:191] run_end_vcn, [255] zero
    output logic [drld_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [drld_pkg::STAT_W-1:0]         m_axis_tuser,  // [2:0] status
    output logic                                m_axis_tlast,  // list_done

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [drld_pkg::APB_AW-1:0]         paddr,
    input  logic [drld_pkg::WORD_W-1:0]         pwdata,
    output logic [drld_pkg::WORD_W-1:0]         prdata,
    output logic                                pready
);
    import drld_pkg::*;

    // decoder state
    t_phase              r_phase,     n_phase;
    logic [NIB_W-1:0]    r_bytes_left, n_bytes_left;
    logic [NIB_W-1:0]    r_len_nib,   n_len_nib;
    logic [NIB_W-1:0]    r_off_nib,   n_off_nib;
    logic [WORD_W-1:0]   r_len_acc,   n_len_acc;
    logic [WORD_W-1:0]   r_off_acc,   n_off_acc;
    logic [WORD_W-1:0]   r_cluster,   n_cluster;
    logic [WORD_W-1:0]   r_vcn,       n_vcn;
    logic                r_stopped,   n_stopped;
    logic [WORD_W-1:0]   r_vcn_bound;

    // result register
    logic                r_m_valid,   n_m_valid;
    logic [STAT_W-1:0]   r_status,    n_status;
    logic [WORD_W-1:0]   r_lcn,       n_lcn;
    logic [CLUS_W-1:0]   r_clusters,  n_clusters;
    logic [WORD_W-1:0]   r_first,     n_first;
    logic [WORD_W-1:0]   r_last,      n_last;

    // working signals
    logic                s_acc;
    logic                w_result;
    logic [DATA_W-1:0]   w_b;
    t_phase              e_phase;
    logic [NIB_W-1:0]    e_bytes_left, e_len_nib, e_off_nib;
    logic [WORD_W-1:0]   e_len_acc, e_off_acc, e_cluster, e_vcn;
    logic                e_stopped;
    logic [NIB_W-1:0]    w_hdr_ln, w_hdr_on;
    logic [2:0]          w_idx;
    logic [NIB_W-1:0]    w_bl_dec;
    logic [WORD_W-1:0]   w_byte_sh;
    logic [WORD_W-1:0]   w_len_new, w_off_new;
    logic                w_do_run;
    logic [WORD_W-1:0]   w_run_len, w_run_off;
    logic [WORD_W-1:0]   w_lcn_sum, w_vcn_sum, w_end_vcn;
    logic                w_cfg_wr;

    assign s_acc         = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = ~r_m_valid | m_axis_tready;
    assign w_b           = s_axis_tdata;

    // list_start clears the list context before the byte is handled
    always_comb begin
        if (s_axis_tuser[0]) begin
            e_phase      = PH_HEADER;
            e_bytes_left = '0;
            e_len_nib    = '0;
            e_off_nib    = '0;
            e_len_acc    = '0;
            e_off_acc    = '0;
            e_cluster    = '0;
            e_vcn        = '0;
            e_stopped    = 1'b0;
        end else begin
            e_phase      = r_phase;
            e_bytes_left = r_bytes_left;
            e_len_nib    = r_len_nib;
            e_off_nib    = r_off_nib;
            e_len_acc    = r_len_acc;
            e_off_acc    = r_off_acc;
            e_cluster    = r_cluster;
            e_vcn        = r_vcn;
            e_stopped    = r_stopped;
        end
    end

    assign w_hdr_ln  = w_b[3:0];
    assign w_hdr_on  = w_b[7:4];
    assign w_bl_dec  = e_bytes_left - 4'd1;
    assign w_idx     = (e_phase == PH_LENGTH) ? 3'(e_len_nib - e_bytes_left)
                                              : 3'(e_off_nib - e_bytes_left);
    assign w_byte_sh = {{(WORD_W-DATA_W){1'b0}}, w_b} << {w_idx, 3'b000};
    assign w_len_new = e_len_acc | w_byte_sh;

    always_comb begin
        w_off_new = e_off_acc | w_byte_sh;
        // sign-extend from the last offset byte
        if (w_bl_dec == '0 && e_off_nib < MAX_NIBBLE && w_b[DATA_W-1])
            w_off_new = w_off_new | ({WORD_W{1'b1}} << {e_off_nib[2:0], 3'b000});
    end

    // run completion arithmetic; the run either closes after the length bytes
    // (no offset bytes, offset is zero) or after the last offset byte
    assign w_run_len  = (e_phase == PH_LENGTH) ? w_len_new : e_len_acc;
    assign w_run_off  = (e_phase == PH_LENGTH) ? e_off_acc : w_off_new;
    assign w_lcn_sum  = e_cluster + w_run_off;
    assign w_vcn_sum  = e_vcn + w_run_len;
    assign w_end_vcn  = e_vcn + w_run_len - 64'd1;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_len_nib    = r_len_nib;
        n_off_nib    = r_off_nib;
        n_len_acc    = r_len_acc;
        n_off_acc    = r_off_acc;
        n_cluster    = r_cluster;
        n_vcn        = r_vcn;
        n_stopped    = r_stopped;
        w_result     = 1'b0;
        w_do_run     = 1'b0;
        n_status     = r_status;
        n_lcn        = r_lcn;
        n_clusters   = r_clusters;
        n_first      = r_first;
        n_last       = r_last;

        if (s_acc) begin
            n_phase      = e_phase;
            n_bytes_left = e_bytes_left;
            n_len_nib    = e_len_nib;
            n_off_nib    = e_off_nib;
            n_len_acc    = e_len_acc;
            n_off_acc    = e_off_acc;
            n_cluster    = e_cluster;
            n_vcn        = e_vcn;
            n_stopped    = e_stopped;

            if (!e_stopped) begin
                case (e_phase)
                    PH_HEADER: begin
                        if (w_b == '0) begin
                            w_result = 1'b1;
                            n_status = ST_END;
                        end else if (w_hdr_ln > MAX_NIBBLE || w_hdr_on > MAX_NIBBLE) begin
                            w_result = 1'b1;
                            n_status = ST_BAD_NIB;
                        end else begin
                            n_len_nib = w_hdr_ln;
                            n_off_nib = w_hdr_on;
                            n_len_acc = '0;
                            n_off_acc = '0;
                            if (w_hdr_ln != '0) begin
                                n_phase      = PH_LENGTH;
                                n_bytes_left = w_hdr_ln;
                            end else begin
                                n_phase      = PH_OFFSET;
                                n_bytes_left = w_hdr_on;
                            end
                        end
                    end
                    PH_LENGTH: begin
                        n_len_acc    = w_len_new;
                        n_bytes_left = w_bl_dec;
                        if (w_bl_dec == '0) begin
                            if (w_len_new[WORD_W-1]) begin
                                w_result = 1'b1;
                                n_status = ST_NEG_LEN;
                            end else if (e_off_nib != '0) begin
                                n_phase      = PH_OFFSET;
                                n_bytes_left = e_off_nib;
                            end else begin
                                w_do_run = 1'b1;
                            end
                        end
                    end
                    PH_OFFSET: begin
                        n_off_acc    = w_off_new;
                        n_bytes_left = w_bl_dec;
                        if (w_bl_dec == '0)
                            w_do_run = 1'b1;
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase

                if (w_do_run) begin
                    w_result     = 1'b1;
                    n_phase      = PH_HEADER;
                    n_bytes_left = '0;
                    if (w_lcn_sum[WORD_W-1]) begin
                        n_status = ST_NEG_LCN;
                    end else begin
                        n_cluster = w_lcn_sum;
                        n_vcn     = w_vcn_sum;
                        if (w_end_vcn > r_vcn_bound) begin
                            n_status = ST_VCN_BOUND;
                        end else begin
                            n_status   = ST_RUN;
                            n_lcn      = (w_run_off == '0) ? {WORD_W{1'b1}} : w_lcn_sum;
                            n_clusters = w_run_len[CLUS_W-1:0];
                            n_first    = e_vcn;
                            n_last     = w_end_vcn;
                        end
                    end
                end

                // end marker and every failure stop the list with zeroed fields
                if (w_result && n_status != ST_RUN) begin
                    n_stopped    = 1'b1;
                    n_phase      = PH_HEADER;
                    n_bytes_left = '0;
                    n_lcn        = '0;
                    n_clusters   = '0;
                    n_first      = '0;
                    n_last       = '0;
                end
            end
        end

        if (w_result)
            n_m_valid = 1'b1;
        else if (m_axis_tready)
            n_m_valid = 1'b0;
        else
            n_m_valid = r_m_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_bytes_left <= '0;
            r_len_nib    <= '0;
            r_off_nib    <= '0;
            r_len_acc    <= '0;
            r_off_acc    <= '0;
            r_cluster    <= '0;
            r_vcn        <= '0;
            r_stopped    <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_len_nib    <= n_len_nib;
            r_off_nib    <= n_off_nib;
            r_len_acc    <= n_len_acc;
            r_off_acc    <= n_off_acc;
            r_cluster    <= n_cluster;
            r_vcn        <= n_vcn;
            r_stopped    <= n_stopped;
            r_m_valid    <= n_m_valid;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_status   <= n_status;
            r_lcn      <= n_lcn;
            r_clusters <= n_clusters;
            r_first    <= n_first;
            r_last     <= n_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = (r_status != ST_RUN);
    assign m_axis_tdata  = {1'b0, r_last, r_first, r_clusters, r_lcn};

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr[3] == REG_VCN_BOUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcn_bound <= '0;
        end else if (w_cfg_wr) begin
            r_vcn_bound <= pwdata;
        end
    end

    assign prdata = (paddr[3] == REG_VCN_BOUND) ? r_vcn_bound : '0;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the run list decoder: directed lists, then random lists and noise.
module tb_top;
    import drld_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned IDLE_PCT    = 26;
    localparam int unsigned PHASE_ITEMS = 215;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam logic [APB_AW-1:0] ADDR_VCN_BOUND = {REG_VCN_BOUND, 3'b000};
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } t_byte_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] lcn;
        logic [CLUS_W-1:0] clusters;
        logic [WORD_W-1:0] first_vcn;
        logic [WORD_W-1:0] end_vcn;
        logic              done;
    } t_run_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata = '0;     // [7:0] data_byte
    logic [0:0]             s_axis_tuser = '0;     // [0] list_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [63:0] run_lcn, [126:64] run_clusters, [190:127] run_first_vcn,
    // [254:191] run_end_vcn, [255] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;          // [2:0] status
    logic                   m_axis_tlast;          // list_done
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [WORD_W-1:0]      pwdata = '0;
    logic [WORD_W-1:0]      prdata;
    logic                   pready;

    t_byte_item  bytes_to_send[$];
    t_run_rec    expected_runs[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned results_checked = 0;
    int unsigned hold_left = 0;
    int unsigned items_queued = 0;
    bit          hold_done = 1'b0;
    bit          steady_flow = 1'b0;

    // decoder state as predicted
    logic [WORD_W-1:0] bound_q;
    t_phase            phase_q;
    logic [NIB_W-1:0]  left_q, len_nib_q, off_nib_q;
    logic [WORD_W-1:0] len_q, off_q, lcn_q, vcn_q;
    logic              halted_q;

    data_run_list_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("ERROR cycle %0d: %s: got 0x%0h, want 0x%0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_list();
        phase_q   = PH_HEADER;
        left_q    = '0;
        len_nib_q = '0;
        off_nib_q = '0;
        len_q     = '0;
        off_q     = '0;
        lcn_q     = '0;
        vcn_q     = '0;
        halted_q  = 1'b0;
    endtask

    task automatic end_list(input logic [STAT_W-1:0] st);
        t_run_rec r;
        halted_q = 1'b1;
        phase_q  = PH_HEADER;
        left_q   = '0;
        r        = '0;
        r.status = st;
        r.done   = 1'b1;
        expected_runs.push_back(r);
    endtask

    task automatic close_run();
        logic [WORD_W-1:0] sum, first, last;
        t_run_rec r;
        phase_q = PH_HEADER;
        left_q  = '0;
        sum     = lcn_q + off_q;
        if (sum[WORD_W-1]) begin
            end_list(ST_NEG_LCN);
        end else begin
            lcn_q = sum;
            first = vcn_q;
            vcn_q = vcn_q + len_q;
            last  = vcn_q - 64'd1;        // wraps for a zero-length first run
            if (last > bound_q) begin
                end_list(ST_VCN_BOUND);
            end else begin
                r.status    = ST_RUN;
                r.lcn       = (off_q == '0) ? ALL_ONES : sum;
                r.clusters  = len_q[CLUS_W-1:0];
                r.first_vcn = first;
                r.end_vcn   = last;
                r.done      = 1'b0;
                expected_runs.push_back(r);
            end
        end
    endtask

    task automatic decode_run_byte(input logic [7:0] b, input logic start);
        logic [2:0] idx;
        if (start)
            clear_list();
        if (halted_q)
            return;
        case (phase_q)
            PH_HEADER: begin
                if (b == 8'h00) begin
                    end_list(ST_END);
                end else if (b[3:0] > MAX_NIBBLE || b[7:4] > MAX_NIBBLE) begin
                    end_list(ST_BAD_NIB);
                end else begin
                    len_nib_q = b[3:0];
                    off_nib_q = b[7:4];
                    len_q     = '0;
                    off_q     = '0;
                    if (b[3:0] != '0) begin
                        phase_q = PH_LENGTH;
                        left_q  = b[3:0];
                    end else begin
                        phase_q = PH_OFFSET;
                        left_q  = b[7:4];
                    end
                end
            end
            PH_LENGTH: begin
                idx    = 3'(len_nib_q - left_q);
                len_q  = len_q | (64'(b) << (8 * idx));
                left_q = left_q - 1'b1;
                if (left_q == '0) begin
                    if (len_q[WORD_W-1]) begin
                        end_list(ST_NEG_LEN);
                    end else if (off_nib_q != '0) begin
                        phase_q = PH_OFFSET;
                        left_q  = off_nib_q;
                    end else begin
                        close_run();
                    end
                end
            end
            default: begin
                idx    = 3'(off_nib_q - left_q);
                off_q  = off_q | (64'(b) << (8 * idx));
                left_q = left_q - 1'b1;
                if (left_q == '0) begin
                    // sign-extend from the last offset byte
                    if (off_nib_q < MAX_NIBBLE && b[7])
                        off_q = off_q | (ALL_ONES << (8 * off_nib_q[2:0]));
                    close_run();
                end
            end
        endcase
    endtask

    // byte driver: predicts on each accepted transaction, then offers the next byte
    always @(posedge i_clk) begin : drive_bytes
        t_byte_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                decode_run_byte(s_axis_tdata, s_axis_tuser[0]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (bytes_to_send.size() != 0 &&
                    (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = bytes_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.value;
                    s_axis_tuser  <= nxt.start;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor, with one long hold-off to back the decoder up
    always @(posedge i_clk) begin : check_results
        t_run_rec want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch("result with none expected", 64'(m_axis_tuser), '0);
                end else begin
                    want = expected_runs.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                    if (m_axis_tdata[63:0] !== want.lcn)
                        report_mismatch("run_lcn", m_axis_tdata[63:0], want.lcn);
                    if (m_axis_tdata[126:64] !== want.clusters)
                        report_mismatch("run_clusters", 64'(m_axis_tdata[126:64]),
                                        64'(want.clusters));
                    if (m_axis_tdata[190:127] !== want.first_vcn)
                        report_mismatch("run_first_vcn", m_axis_tdata[190:127], want.first_vcn);
                    if (m_axis_tdata[254:191] !== want.end_vcn)
                        report_mismatch("run_end_vcn", m_axis_tdata[254:191], want.end_vcn);
                    if (m_axis_tlast !== want.done)
                        report_mismatch("list_done", 64'(m_axis_tlast), 64'(want.done));
                    results_checked++;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
            end else if (results_checked >= 60 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            m_axis_tready <= (hold_left == 0) &&
                             (steady_flow || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic queue_byte(input logic [7:0] v, input logic start);
        t_byte_item it;
        it.value = v;
        it.start = start;
        bytes_to_send.push_back(it);
        items_queued++;
    endtask

    // well-formed list with random content; sometimes left without its end marker
    task automatic queue_random_list();
        int unsigned n_runs, ln, on;
        logic [7:0] b;
        n_runs = $urandom_range(1, 6);
        for (int r = 0; r < n_runs; r++) begin
            ln = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
            on = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
            if (ln == 0 && on == 0)
                ln = 1;
            queue_byte({on[3:0], ln[3:0]}, r == 0);
            for (int k = 0; k < ln; k++) begin
                b = 8'($urandom);
                if (k == ln - 1 && ln == 8 && $urandom_range(0, 3) != 0)
                    b[7] = 1'b0;
                queue_byte(b, 1'b0);
            end
            for (int k = 0; k < on; k++) begin
                b = 8'($urandom);
                // keep the first cluster mostly positive
                if (k == on - 1 && r == 0 && $urandom_range(0, 3) != 0)
                    b[7] = 1'b0;
                queue_byte(b, 1'b0);
            end
        end
        if ($urandom_range(0, 7) != 0)
            queue_byte(8'h00, 1'b0);
    endtask

    task automatic queue_random_phase();
        int unsigned n;
        items_queued = 0;
        while (items_queued < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_random_list();
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || s_axis_tvalid || expected_runs.size() != 0)
            @(posedge i_clk);
        // a byte with no result may still be in flight
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_vcn_bound(input logic [WORD_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VCN_BOUND;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bound_q = v;
    endtask

    initial begin
        bound_q = '0;
        clear_list();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bound still at reset (zero): zero-length first run, ignored byte, one-cluster run
        queue_byte(8'h10, 1'b1);
        queue_byte(8'h05, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h11, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h07, 1'b0);
        wait_drained();

        write_vcn_bound(ALL_ONES);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h09, 1'b1);
        queue_byte(8'h90, 1'b1);
        queue_byte(8'h11, 1'b1);
        queue_byte(8'h05, 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h01, 1'b0);          // sparse run
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h08, 1'b1);          // eighth length byte negative
        repeat (7) queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h11, 1'b1);          // offset -1 from cluster 0
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b0);
        wait_drained();

        queue_random_phase();
        wait_drained();

        write_vcn_bound({$urandom, $urandom});
        steady_flow = 1'b1;
        queue_random_phase();
        wait_drained();
        steady_flow = 1'b0;

        write_vcn_bound(64'h0000_0000_0100_0000);
        queue_random_phase();
        wait_drained();

        write_vcn_bound('0);
        queue_random_phase();
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
